>>> src/fpdq_pkg.sv
// fpdq_pkg: word types, stage record and stage-boundary functions for the q16.16 divider
`default_nettype none
package fpdq_pkg;

    localparam logic [31:0] LARGE_DIVISOR = 32'h0100_0000;
    localparam int INT_SHIFT   = 16;
    localparam int DIGIT_SHIFT = 8;
    localparam int INT_CELLS   = 32;
    localparam int FRAC_CELLS  = 9;
    localparam int NUM_CELLS   = INT_CELLS + 2 * FRAC_CELLS;

    typedef struct packed {
        logic signed [31:0] dividend;
        logic signed [31:0] divisor;
    } req_t;

    typedef struct packed {
        logic signed [31:0] quotient;
        logic               divide_by_zero;
    } rsp_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] src;
        logic [31:0] dvs;
        logic [31:0] quot;
        logic [31:0] qint;
        logic [8:0]  qhi;
        logic [31:0] bmag;
        logic        wide;
        logic        neg;
        logic        dz;
    } stage_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic stage_t load_word(input req_t w);
        stage_t s;
        logic [31:0] a;
        logic [31:0] b;
        a = mag32(w.dividend);
        b = mag32(w.divisor);
        s       = '0;
        s.src   = a;
        s.dvs   = b;
        s.bmag  = b;
        s.neg   = w.dividend[31] ^ w.divisor[31];
        s.dz    = (b == 32'd0);
        load_word = s;
    endfunction

    // integer part done: set up the first fraction digit
    function automatic stage_t to_frac_a(input stage_t s);
        stage_t t;
        logic [31:0] r;
        t      = s;
        r      = s.rem[31:0];
        t.qint = s.quot;
        t.quot = '0;
        t.wide = (s.bmag >= LARGE_DIVISOR);
        if (t.wide)
        begin
            t.rem = {10'd0, r[31:9]};
            t.src = {r[8:0], 23'd0};
            t.dvs = {8'd0, s.bmag[31:8]};
        end
        else
        begin
            t.rem = {1'b0, r};
            t.src = '0;
            t.dvs = s.bmag;
        end
        to_frac_a = t;
    endfunction

    // first fraction digit done: set up the second
    function automatic stage_t to_frac_b(input stage_t s);
        stage_t t;
        t      = s;
        t.qhi  = s.quot[8:0];
        t.quot = '0;
        if (s.wide)
        begin
            t.rem = {10'd0, s.rem[31:9]};
            t.src = {s.rem[8:0], 23'd0};
            t.dvs = {16'd0, s.bmag[31:16]};
        end
        else
        begin
            t.src = '0;
            t.dvs = s.bmag;
        end
        to_frac_b = t;
    endfunction

    function automatic rsp_t finish(input stage_t s);
        rsp_t o;
        logic [31:0] frac;
        logic [17:0] both;
        logic [31:0] res;
        both = {s.qhi, s.quot[8:0]};
        if (s.wide)
            frac = {15'd0, s.qhi, 8'd0} + {23'd0, s.quot[8:0]};
        else
            frac = {16'd0, both[17:2]};
        res = {s.qint[15:0], 16'd0} + frac;
        if (s.neg)
            res = 32'd0 - res;
        o.quotient       = s.dz ? 32'sd0 : $signed(res);
        o.divide_by_zero = s.dz;
        finish = o;
    endfunction

endpackage
`default_nettype wire

>>> src/fpdq_cell.sv
// fpdq_cell: one restoring divide step with its own valid/ready stage register
`default_nettype none
module fpdq_cell
    import fpdq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_ready,
    input  wire stage_t up_data,
    output logic        dn_valid,
    input  wire logic   dn_ready,
    output stage_t      dn_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic [32:0] shifted;
    logic        take;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next = up_data;
        shifted   = {up_data.rem[31:0], up_data.src[31]};
        take      = (shifted >= {1'b0, up_data.dvs});
        data_next.rem  = take ? (shifted - {1'b0, up_data.dvs}) : shifted;
        data_next.src  = {up_data.src[30:0], 1'b0};
        data_next.quot = {up_data.quot[30:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

>>> src/fixed_point_divide_q16_core.sv
// fixed_point_divide_q16_core: pipelined signed 16.16 divider built from a row of divide cells
//
// req channel (req_valid/req_ready/req) takes a word of dividend and divisor,
// rsp channel (rsp_valid/rsp_ready/rsp) returns quotient and divide_by_zero.
// one rsp word per req word, in order.
// the row has 50 cells: 32 for the integer quotient, then two groups of 9
// for the fraction digits; each cell is one register stage.
// rsp_valid rises once the req word has passed through all 50 cell registers.
// a new word can be accepted every cycle while a stalled receiver does not block the row.
// each cell holds its own valid bit and takes a word whenever it is empty or
// its neighbor is moving, so a stalled receiver fills the row from the end
// and req_ready falls only once the first cell is occupied and blocked.
// reset clears all valid bits; the row comes up empty and ready.
// a zero divisor gives quotient 0 with divide_by_zero set.
`default_nettype none
module fixed_point_divide_q16_core
    import fpdq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    stage_t link_data  [0:NUM_CELLS];
    logic   link_valid [0:NUM_CELLS];
    logic   link_ready [0:NUM_CELLS];

    assign link_data[0]  = load_word(req);
    assign link_valid[0] = req_valid;
    assign req_ready     = link_ready[0];

    genvar i;
    generate
        for (i = 0; i < NUM_CELLS; i++)
        begin : g_cell
            stage_t cell_in;
            if (i == INT_CELLS)
            begin : g_ja
                assign cell_in = to_frac_a(link_data[i]);
            end
            else if (i == INT_CELLS + FRAC_CELLS)
            begin : g_jb
                assign cell_in = to_frac_b(link_data[i]);
            end
            else
            begin : g_pass
                assign cell_in = link_data[i];
            end

            fpdq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (link_valid[i]),
                .up_ready (link_ready[i]),
                .up_data  (cell_in),
                .dn_valid (link_valid[i+1]),
                .dn_ready (link_ready[i+1]),
                .dn_data  (link_data[i+1])
            );
        end
    endgenerate

    assign link_ready[NUM_CELLS] = rsp_ready;
    assign rsp_valid = link_valid[NUM_CELLS];
    assign rsp       = finish(link_data[NUM_CELLS]);

endmodule
`default_nettype wire

>>> verif/fixed_point_divide_q16_core_tb.sv
// fixed_point_divide_q16_core_tb: random and directed checks of the q16.16 divider against a predictor
`default_nettype none
module fixed_point_divide_q16_core_tb;
    import fpdq_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    req_t pending_words[$];
    rsp_t expected_quotients[$];
    int   mismatches;
    int   checked;
    int   dz_seen;
    bit   stim_done;
    bit   hold_sender;
    int   rx_stall_left;
    bit   rx_no_idle;
    bit   tx_no_idle;

    fixed_point_divide_q16_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    function automatic logic [31:0] abs_wrap(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic rsp_t predict_quotient(input req_t w);
        rsp_t o;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] res;
        logic [31:0] b8;
        logic [31:0] b16;
        logic [31:0] r8;
        a = abs_wrap(w.dividend);
        b = abs_wrap(w.divisor);
        o.divide_by_zero = (b == 32'd0);
        o.quotient = '0;
        if (b != 32'd0)
        begin
            r = a % b;
            res = (a / b) << 16;
            if (b >= 32'h0100_0000)
            begin
                // coarse fraction for wide divisors
                b8 = b >> 8;
                b16 = b >> 16;
                res = (r % b8) / b16 + res + ((r / b8) << 8);
            end
            else
            begin
                r8 = r << 8;
                res = (((r8 % b) << 8) / b) + res + ((r8 / b) << 8);
            end
            if (w.dividend[31] ^ w.divisor[31])
                res = 32'd0 - res;
            o.quotient = res;
        end
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 6))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0001_FFFF);
            2: return 32'd0 - $urandom_range(0, 32'h0001_FFFF);
            3: return $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
            4: return 32'd0 - $urandom_range(32'h00FF_F000, 32'h0100_1000);
            5: return $urandom_range(0, 32'h00FF_FFFF);
            default: return {1'($urandom_range(0, 1)), 7'd0, 24'($urandom)};
        endcase
    endfunction

    task automatic add_word(input logic [31:0] n, input logic [31:0] d);
        req_t w;
        w.dividend = n;
        w.divisor = d;
        pending_words.push_back(w);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20000000;
        $display("timeout at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_words.size() != 0 && !hold_sender
                && (tx_no_idle || $urandom_range(0, 99) >= 29))
            begin
                req_valid <= 1'b1;
                req <= pending_words[0];
                expected_quotients.push_back(predict_quotient(pending_words[0]));
                void'(pending_words.pop_front());
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver ready and long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (rx_stall_left > 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= rx_no_idle || ($urandom_range(0, 99) >= 29);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_quotients.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word q=%h dz=%b", $time, rsp.quotient,
                    rsp.divide_by_zero);
            end
            else
            begin
                if (rsp.quotient !== expected_quotients[0].quotient
                    || rsp.divide_by_zero !== expected_quotients[0].divide_by_zero)
                begin
                    mismatches++;
                    $display("%0t: expected q=%h dz=%b actual q=%h dz=%b", $time,
                        expected_quotients[0].quotient,
                        expected_quotients[0].divide_by_zero,
                        rsp.quotient, rsp.divide_by_zero);
                end
                if (expected_quotients[0].divide_by_zero)
                    dz_seen++;
                checked++;
                void'(expected_quotients.pop_front());
            end
        end
    end

    initial
    begin
        int k;
        int waited;
        mismatches = 0;
        checked = 0;
        dz_seen = 0;
        stim_done = 0;
        hold_sender = 0;
        rx_stall_left = 0;
        rx_no_idle = 0;
        tx_no_idle = 0;
        // field extremes, zero divisor, most negative, overflow, both fraction paths
        add_word(32'h0001_0000, 32'h0000_0000);
        add_word(32'h8000_0000, 32'h0000_0000);
        add_word(32'h0000_0000, 32'h0001_0000);
        add_word(32'h7FFF_FFFF, 32'h0000_0001);
        add_word(32'h8000_0000, 32'h0000_0001);
        add_word(32'h8000_0000, 32'hFFFF_FFFF);
        add_word(32'h8000_0000, 32'h8000_0000);
        add_word(32'h7FFF_FFFF, 32'h8000_0000);
        add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_word(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_word(32'h0003_0000, 32'h0002_0000);
        add_word(32'hFFFD_0000, 32'h0002_0000);
        add_word(32'h0001_0000, 32'hFFFD_0000);
        add_word(32'h0100_0000, 32'h00FF_FFFF);
        add_word(32'h7FFF_FFFF, 32'h0100_0000);
        add_word(32'h1234_5678, 32'h0123_4567);
        add_word(32'hEDCB_A988, 32'h0100_0001);
        add_word(32'h0000_0001, 32'h0000_0003);
        add_word(32'h0000_0000, 32'h8000_0000);
        add_word(32'h5555_5555, 32'hAAAA_AAAA);
        for (k = 0; k < 300; k++)
            add_word(rand_operand(), ($urandom_range(0, 40) == 0) ? 32'd0 : rand_operand());
        wait (pending_words.size() == 0);
        // sender pauses until the pipe drains
        hold_sender = 1;
        wait (expected_quotients.size() == 0);
        hold_sender = 0;
        // long receiver hold-off with a steady sender fills the row
        tx_no_idle = 1;
        for (k = 0; k < 200; k++)
            add_word(rand_operand(), rand_operand());
        @(posedge clk);
        rx_stall_left <= 150;
        wait (pending_words.size() == 0);
        // no idling on either side for a stretch
        rx_no_idle = 1;
        for (k = 0; k < 150; k++)
            add_word(rand_operand(), ($urandom_range(0, 30) == 0) ? 32'd0 : rand_operand());
        wait (pending_words.size() == 0);
        rx_no_idle = 0;
        tx_no_idle = 0;
        for (k = 0; k < 250; k++)
            add_word(rand_operand(), ($urandom_range(0, 30) == 0) ? 32'd0 : rand_operand());
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (req_valid && !req_ready)
            @(posedge clk);
        waited = 0;
        while (expected_quotients.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (expected_quotients.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d words never returned", $time, expected_quotients.size());
        end
        $display("covered %0d quotients (%0d zero divisors), stalls, drain and full-row backpressure",
            checked, dz_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
src/fpdq_pkg.sv
src/fpdq_cell.sv
src/fixed_point_divide_q16_core.sv
verif/fixed_point_divide_q16_core_tb.sv
